@@ rtl/dspc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and constants for the delta sample playback channel.
// No dependencies; the register, step and top modules import this package.
package dspc_pkg;

  // Operation codes carried on the input channel
  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_DELIVER    = 3'd1,
    OP_ENABLE     = 3'd2,
    OP_IRQ_ACK    = 3'd3,
    OP_LEVEL_LOAD = 3'd4
  } op_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_RATE_PERIOD   = 3'd0,
    CFG_LOOP_ENABLE   = 3'd1,
    CFG_IRQ_ENABLE    = 3'd2,
    CFG_SAMPLE_START  = 3'd3,
    CFG_SAMPLE_LENGTH = 3'd4
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 10;

  localparam logic [15:0] BaseAddr      = 16'hC000;
  localparam logic [15:0] WrapAddr      = 16'h8000;
  localparam logic [15:0] TopAddr       = 16'hFFFF;
  localparam logic [6:0]  LevelUpMax    = 7'd125;
  localparam logic [3:0]  BitsPerByte   = 4'd8;
  localparam logic [9:0]  RatePeriodRst = 10'd428;

  // One input beat
  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] sample_byte;
    logic       enable_bit;
    logic [6:0] level_value;
  } in_beat_t;

  // One result beat
  typedef struct packed {
    logic        dma_request;
    logic [15:0] dma_address;
    logic [6:0]  output_level;
    logic        irq_flag;
    logic        active;
  } out_beat_t;

endpackage

@@ rtl/dspc_in_if.sv @@
`timescale 1ns / 1ps
// Input channel: valid/ready handshake carrying one operation beat.
// Depends on nothing but the signal widths of dspc_pkg.
interface dspc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] sample_byte;
  logic       enable_bit;
  logic [6:0] level_value;

  modport source (output valid, output operation, output sample_byte,
                  output enable_bit, output level_value, input ready);
  modport sink   (input valid, input operation, input sample_byte,
                  input enable_bit, input level_value, output ready);
endinterface

@@ rtl/dspc_out_if.sv @@
`timescale 1ns / 1ps
// Result channel: valid/ready handshake carrying one result beat.
// Depends on nothing but the signal widths of dspc_pkg.
interface dspc_out_if;
  logic        valid;
  logic        ready;
  logic        dma_request;
  logic [15:0] dma_address;
  logic [6:0]  output_level;
  logic        irq_flag;
  logic        active;

  modport source (output valid, output dma_request, output dma_address,
                  output output_level, output irq_flag, output active, input ready);
  modport sink   (input valid, input dma_request, input dma_address,
                  input output_level, input irq_flag, input active, output ready);
endinterface

@@ rtl/dspc_cfg_if.sv @@
`timescale 1ns / 1ps
// Configuration write channel: valid/ready with register index and data.
// Widths follow CfgIdxW and CfgDataW of dspc_pkg.
interface dspc_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [9:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/dspc_in_reg.sv @@
`timescale 1ns / 1ps
// Input register stage: captures one operation beat and holds it until
// the step stage consumes it. Uses in_beat_t from dspc_pkg.
module dspc_in_reg import dspc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  in_beat_t beat_i,
  output logic     ready_o,
  input  logic     take_i,
  output logic     valid_o,
  output in_beat_t beat_o
);

  logic     valid_q, valid_d;
  in_beat_t beat_q;

  // Room when empty or when the held beat leaves this cycle
  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      beat_q <= beat_i;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

@@ rtl/dspc_step.sv @@
`timescale 1ns / 1ps
// Channel state, configuration registers and the one-beat update logic.
// Uses op_e, cfg_idx_e, the beat structs and constants of dspc_pkg.
module dspc_step import dspc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  in_beat_t            beat_i,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output out_beat_t           result_o
);

  // Configuration
  logic [9:0]  rate_period_q, rate_period_d;
  logic        loop_en_q, loop_en_d;
  logic        irq_en_q, irq_en_d;
  logic [7:0]  start_q, start_d;
  logic [7:0]  length_q, length_d;

  // Channel state
  logic [9:0]  divider_q, divider_d;
  logic [7:0]  shifter_q, shifter_d;
  logic [3:0]  bits_left_q, bits_left_d;
  logic [7:0]  held_byte_q, held_byte_d;
  logic        held_empty_q, held_empty_d;
  logic        silenced_q, silenced_d;
  logic [15:0] fetch_addr_q, fetch_addr_d;
  logic [11:0] bytes_left_q, bytes_left_d;
  logic [6:0]  level_q, level_d;
  logic        irq_q, irq_d;
  logic        chan_on_q, chan_on_d;

  logic [15:0] restart_addr;
  logic [11:0] restart_len;
  logic        req;
  logic [15:0] addr;

  // Sample start address and length from the config codes
  assign restart_addr = BaseAddr + {2'b00, start_q, 6'b000000};
  assign restart_len  = {length_q, 4'b0001};

  // Next state for one beat, then config writes on top
  always_comb begin
    rate_period_d = rate_period_q;
    loop_en_d     = loop_en_q;
    irq_en_d      = irq_en_q;
    start_d       = start_q;
    length_d      = length_q;
    divider_d     = divider_q;
    shifter_d     = shifter_q;
    bits_left_d   = bits_left_q;
    held_byte_d   = held_byte_q;
    held_empty_d  = held_empty_q;
    silenced_d    = silenced_q;
    fetch_addr_d  = fetch_addr_q;
    bytes_left_d  = bytes_left_q;
    level_d       = level_q;
    irq_d         = irq_q;
    chan_on_d     = chan_on_q;
    req           = 1'b0;
    addr          = 16'h0000;

    if (step_i) begin
      unique case (beat_i.operation)
        OP_TICK: begin
          if (chan_on_q) begin
            if (divider_q == 10'd0) begin
              divider_d = rate_period_q;
              if (!silenced_q) begin
                // one delta bit: up or down by two, clamped
                if (shifter_q[0]) begin
                  if (level_q <= LevelUpMax) begin
                    level_d = level_q + 7'd2;
                  end
                end else if (level_q >= 7'd2) begin
                  level_d = level_q - 7'd2;
                end
                shifter_d   = shifter_q >> 1;
                bits_left_d = bits_left_q - 4'd1;
                // byte finished: reload shifter from the buffer, or go silent if it is empty
                if (bits_left_q == 4'd1) begin
                  bits_left_d = BitsPerByte;
                  if (held_empty_q) begin
                    silenced_d = 1'b1;
                  end else begin
                    silenced_d   = 1'b0;
                    shifter_d    = held_byte_q;
                    held_empty_d = 1'b1;
                    if (bytes_left_q != 12'd0) begin
                      req  = 1'b1;
                      addr = fetch_addr_q;
                    end else if (loop_en_q) begin
                      req          = 1'b1;
                      addr         = restart_addr;
                      fetch_addr_d = restart_addr;
                      bytes_left_d = restart_len;
                    end else if (irq_en_q) begin
                      irq_d = 1'b1;
                    end
                  end
                end
              end
            end else begin
              divider_d = divider_q - 10'd1;
            end
          end
        end
        OP_DELIVER: begin
          held_byte_d  = beat_i.sample_byte;
          held_empty_d = 1'b0;
          silenced_d   = 1'b0;
          fetch_addr_d = (fetch_addr_q == TopAddr) ? WrapAddr : fetch_addr_q + 16'd1;
          if (bytes_left_q != 12'd0) begin
            bytes_left_d = bytes_left_q - 12'd1;
          end
        end
        OP_ENABLE: begin
          chan_on_d = beat_i.enable_bit;
          irq_d     = 1'b0;
          if (!beat_i.enable_bit) begin
            bytes_left_d = 12'd0;
          end else if (bytes_left_q == 12'd0) begin
            silenced_d   = 1'b1;
            req          = 1'b1;
            addr         = restart_addr;
            fetch_addr_d = restart_addr;
            bytes_left_d = restart_len;
          end
        end
        OP_IRQ_ACK: begin
          irq_d = 1'b0;
        end
        OP_LEVEL_LOAD: begin
          level_d = beat_i.level_value;
        end
        default: begin
        end
      endcase
    end

    // Register writes (the user must send them only while the channel pipeline is idle; not enforced here)
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_RATE_PERIOD: begin
          rate_period_d = cfg_data_i;
          divider_d     = cfg_data_i;
        end
        CFG_LOOP_ENABLE: begin
          loop_en_d = cfg_data_i[0];
        end
        CFG_IRQ_ENABLE: begin
          irq_en_d = cfg_data_i[0];
          if (!cfg_data_i[0]) begin
            irq_d = 1'b0;
          end
        end
        CFG_SAMPLE_START: begin
          start_d = cfg_data_i[7:0];
        end
        CFG_SAMPLE_LENGTH: begin
          length_d = cfg_data_i[7:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_period_q <= RatePeriodRst;
      loop_en_q     <= 1'b0;
      irq_en_q      <= 1'b0;
      start_q       <= 8'd0;
      length_q      <= 8'd0;
      divider_q     <= 10'd0;
      shifter_q     <= 8'd0;
      bits_left_q   <= BitsPerByte;
      held_byte_q   <= 8'd0;
      held_empty_q  <= 1'b1;
      silenced_q    <= 1'b1;
      fetch_addr_q  <= BaseAddr;
      bytes_left_q  <= 12'd0;
      level_q       <= 7'd0;
      irq_q         <= 1'b0;
      chan_on_q     <= 1'b0;
    end else begin
      rate_period_q <= rate_period_d;
      loop_en_q     <= loop_en_d;
      irq_en_q      <= irq_en_d;
      start_q       <= start_d;
      length_q      <= length_d;
      divider_q     <= divider_d;
      shifter_q     <= shifter_d;
      bits_left_q   <= bits_left_d;
      held_byte_q   <= held_byte_d;
      held_empty_q  <= held_empty_d;
      silenced_q    <= silenced_d;
      fetch_addr_q  <= fetch_addr_d;
      bytes_left_q  <= bytes_left_d;
      level_q       <= level_d;
      irq_q         <= irq_d;
      chan_on_q     <= chan_on_d;
    end
  end

  // Result reflects the state after this beat
  assign result_o.dma_request  = req;
  assign result_o.dma_address  = addr;
  assign result_o.output_level = level_d;
  assign result_o.irq_flag     = irq_d;
  assign result_o.active       = (bytes_left_d != 12'd0);

endmodule

@@ rtl/dspc_out_reg.sv @@
`timescale 1ns / 1ps
// Result register: holds one result beat until the sink takes it.
// Uses out_beat_t from dspc_pkg.
module dspc_out_reg import dspc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  out_beat_t beat_i,
  output logic      room_o,
  output logic      valid_o,
  input  logic      ready_i,
  output out_beat_t beat_o
);

  logic      valid_q, valid_d;
  out_beat_t beat_q;

  // A new result may land when empty or when the held one is taken now
  assign room_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      beat_q <= beat_i;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

@@ rtl/delta_sample_playback_channel.sv @@
`timescale 1ns / 1ps
// Delta sample playback channel, top level.
// Path: an accepted beat is registered in the input register, then in the result register;
// a stalled result register holds the input register. Throughput: one beat per cycle
// unless the result sink stalls; each register takes a beat per cycle, one pass of logic.
// Reset: asynchronous, active low; control state and config return to their defaults, payloads are not reset.
module delta_sample_playback_channel import dspc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  dspc_in_if.sink    in_i,
  dspc_out_if.source out_o,
  dspc_cfg_if.sink   cfg_i
);

  in_beat_t  in_beat, held_beat;
  out_beat_t result, out_beat;
  logic      held_valid, out_room, step;

  assign in_beat.operation   = in_i.operation;
  assign in_beat.sample_byte = in_i.sample_byte;
  assign in_beat.enable_bit  = in_i.enable_bit;
  assign in_beat.level_value = in_i.level_value;

  // Held beat moves on when the result register has room
  assign step = held_valid && out_room;

  dspc_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .beat_i  (in_beat),
    .ready_o (in_i.ready),
    .take_i  (step),
    .valid_o (held_valid),
    .beat_o  (held_beat)
  );

  dspc_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .beat_i      (held_beat),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .result_o    (result)
  );

  dspc_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step),
    .beat_i  (result),
    .room_o  (out_room),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .beat_o  (out_beat)
  );

  // Config writes are always taken
  assign cfg_i.ready = 1'b1;

  assign out_o.dma_request  = out_beat.dma_request;
  assign out_o.dma_address  = out_beat.dma_address;
  assign out_o.output_level = out_beat.output_level;
  assign out_o.irq_flag     = out_beat.irq_flag;
  assign out_o.active       = out_beat.active;

endmodule

@@ rtl/dspc_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks on the result channel of the playback channel.
// Bound to delta_sample_playback_channel; no package dependency.
module dspc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        ready_i,
  input logic        dma_request_i,
  input logic [15:0] dma_address_i,
  input logic [6:0]  output_level_i,
  input logic        irq_flag_i,
  input logic        active_i
);

  // No address without a fetch request
  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !dma_request_i |-> dma_address_i == 16'h0000)
    else $error("dma_address nonzero without dma_request");

  // A fetch always leaves bytes to fetch
  a_req_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && dma_request_i |-> active_i)
    else $error("dma_request with channel inactive");

  // Fetch addresses stay in the upper half of the address space
  a_req_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && dma_request_i |-> dma_address_i[15])
    else $error("dma_address below 0x8000");

  // A stalled result beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(dma_request_i) && $stable(dma_address_i)
      && $stable(output_level_i) && $stable(irq_flag_i) && $stable(active_i))
    else $error("stalled result beat changed");

endmodule

bind delta_sample_playback_channel dspc_checker u_dspc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .valid_i        (out_o.valid),
  .ready_i        (out_o.ready),
  .dma_request_i  (out_o.dma_request),
  .dma_address_i  (out_o.dma_address),
  .output_level_i (out_o.output_level),
  .irq_flag_i     (out_o.irq_flag),
  .active_i       (out_o.active)
);
